@@ rtl/rlf_pkg.sv @@
// shared types and constants of the recursive lock with fifo wait queue
`default_nettype none
package rlf_pkg;

    // thread space and ring geometry
    localparam int THREADS      = 64;
    localparam int TID_W        = 6;
    localparam int FILL_W       = 7;
    localparam int COUNT_W      = 8;
    localparam int MAX_REPEAT   = 255;
    localparam int REPEAT_LIMIT = (MAX_REPEAT < 255) ? MAX_REPEAT : 255;

    // stream word widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;

    // request kinds
    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    // result codes
    typedef enum logic [2:0] {
        ST_GRANTED    = 3'd0,
        ST_REPEAT     = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_PARTIAL    = 3'd3,
        ST_FREED      = 3'd4,
        ST_HANDOFF    = 3'd5,
        ST_NOT_HOLDER = 3'd6,
        ST_ERROR      = 3'd7
    } t_status;

    // one result word
    typedef struct packed {
        logic [COUNT_W-1:0] hold_count;
        logic [TID_W-1:0]   woken_thread;
        logic               woken_valid;
        t_status            status;
    } t_result;

    // write and read request to the wait ring
    typedef struct packed {
        logic             we;
        logic [TID_W-1:0] waddr;
        logic [TID_W-1:0] wdata;
        logic [TID_W-1:0] raddr;
    } t_ring_req;

    // lock state visible to the top level
    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
        logic [FILL_W-1:0]  fill;
    } t_lock_stat;

endpackage
`default_nettype wire

@@ rtl/recursive_lock_fifo_waiters_core.sv @@
// top level of the recursive lock with fifo wait queue
//
// Usage: each input word carries one request. i_s_tuser[0] is the kind
// (0 acquire, 1 release) and i_s_tdata[5:0] the requesting thread id.
// Each request yields exactly one output word with the status, the woken
// thread on a hand-off and the holder's repeat count after the request.
// An accepted request raises o_m_tvalid once it has passed the input
// register, then the decision logic, lock state and ring update feeding
// the output register; a stall can hold it in the input register.
// Throughput is one request per cycle while i_m_tready is high; the state
// update of a request completes in the cycle it leaves the input
// register, and the head entry of the wait ring is prefetched through the
// ring's registered read port so a hand-off never waits for memory.
// Reset (i_rst_n low, synchronous) frees the lock, empties the queue and
// clears every waiting mark; ring contents need no clearing.
// When the receiver holds i_m_tready low the output word is held, the input
// register still fills, and o_s_tready drops once both stages are occupied.
`default_nettype none
module recursive_lock_fifo_waiters_core
    import rlf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // thread_id[5:0], zero pad
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,   // operation[0]
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata    // status[2:0], woken_valid[3],
                                                    // woken_thread[9:4],
                                                    // hold_count[17:10], zero pad
);

    logic             r_in_valid;
    t_op              r_in_op;
    logic [TID_W-1:0] r_in_tid;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;
    logic             fire;
    t_result          result;
    t_ring_req        ring_req;
    logic [TID_W-1:0] head_word;
    t_lock_stat       stat;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op  <= t_op'(i_s_tuser[0]);
            r_in_tid <= i_s_tdata[TID_W-1:0];
        end
    end

    rlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_op        (r_in_op),
        .i_tid       (r_in_tid),
        .i_head_word (head_word),
        .o_result    (result),
        .o_ring_req  (ring_req),
        .o_stat      (stat)
    );

    rlf_ring u_ring (
        .i_clk       (i_clk),
        .i_req       (ring_req),
        .o_head_word (head_word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef NO_ASSERTIONS
    // queue never holds more waiters than there are threads
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fill <= FILL_W'(THREADS))
        else $error("wait queue over capacity");

    // a held lock always has a nonzero count, a free one a zero count
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy == (stat.count != '0))
        else $error("repeat count disagrees with lock state");

    // waiters only exist while the lock is held
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.fill != '0) |-> stat.busy)
        else $error("waiters queued on a free lock");

    // a hand-off leaves the woken thread holding with count one
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && result.status == ST_HANDOFF) |=> (stat.busy && stat.count == COUNT_W'(1)))
        else $error("hand-off did not pass the lock");
`endif

endmodule
`default_nettype wire

@@ rtl/rlf_ring.sv @@
// wait ring memory with registered, write-through read of the next head entry
`default_nettype none
module rlf_ring
    import rlf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_ring_req        i_req,
    output logic [TID_W-1:0]      o_head_word
);

    logic [TID_W-1:0] r_mem [THREADS];
    logic [TID_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port, new data forwarded when it lands on the read address
    always_ff @(posedge i_clk) begin
        if (i_req.we && (i_req.waddr == i_req.raddr)) begin
            r_rd_data <= i_req.wdata;
        end else begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_head_word = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/rlf_ctrl.sv @@
// lock state, waiting marks and per-request decision logic
`default_nettype none
module rlf_ctrl
    import rlf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire t_op              i_op,
    input  wire logic [TID_W-1:0] i_tid,
    input  wire logic [TID_W-1:0] i_head_word,
    output t_result               o_result,
    output t_ring_req             o_ring_req,
    output t_lock_stat            o_stat
);

    logic               r_busy, n_busy;
    logic [TID_W-1:0]   r_owner, n_owner;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TID_W-1:0]   r_head, n_head;
    logic [TID_W-1:0]   r_tail, n_tail;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [THREADS-1:0] r_mark, n_mark;

    logic               tid_bad;
    logic [TID_W-1:0]   next_thread;
    logic               ring_we;
    t_status            status;
    logic               woken;

    assign tid_bad     = ({1'b0, i_tid} >= FILL_W'(THREADS));
    assign next_thread = i_head_word;

    // decision for one request
    always_comb begin
        n_busy  = r_busy;
        n_owner = r_owner;
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_mark  = r_mark;
        ring_we = 1'b0;
        woken   = 1'b0;
        status  = ST_ERROR;
        if (i_op == OP_ACQUIRE) begin
            priority if (tid_bad || r_mark[i_tid]) begin
                status = ST_ERROR;
            end else if (!r_busy) begin
                n_busy  = 1'b1;
                n_owner = i_tid;
                n_count = COUNT_W'(1);
                status  = ST_GRANTED;
            end else if (r_owner == i_tid) begin
                if (r_count >= COUNT_W'(REPEAT_LIMIT)) begin
                    status = ST_ERROR;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                    status  = ST_REPEAT;
                end
            end else if (r_fill >= FILL_W'(THREADS)) begin
                status = ST_ERROR;
            end else begin
                ring_we        = 1'b1;
                n_tail         = (r_tail == TID_W'(THREADS - 1)) ? '0 : r_tail + TID_W'(1);
                n_fill         = r_fill + FILL_W'(1);
                n_mark[i_tid]  = 1'b1;
                status         = ST_QUEUED;
            end
        end else begin
            priority if (!r_busy || (r_owner != i_tid)) begin
                status = ST_NOT_HOLDER;
            end else if (r_count > COUNT_W'(1)) begin
                n_count = r_count - COUNT_W'(1);
                status  = ST_PARTIAL;
            end else if (r_fill == '0) begin
                n_busy  = 1'b0;
                n_owner = '0;
                n_count = '0;
                status  = ST_FREED;
            end else begin
                n_head              = (r_head == TID_W'(THREADS - 1)) ? '0 : r_head + TID_W'(1);
                n_fill              = r_fill - FILL_W'(1);
                n_mark[next_thread] = 1'b0;
                n_owner             = next_thread;
                n_count             = COUNT_W'(1);
                woken               = 1'b1;
                status              = ST_HANDOFF;
            end
        end
    end

    // state registers, updated only for an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_owner <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_mark  <= '0;
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_owner <= n_owner;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_mark  <= n_mark;
        end
    end

    // ring requests: read always targets the head of the coming cycle
    always_comb begin
        o_ring_req.we    = i_fire && ring_we;
        o_ring_req.waddr = r_tail;
        o_ring_req.wdata = i_tid;
        o_ring_req.raddr = i_fire ? n_head : r_head;
    end

    // result word
    always_comb begin
        o_result.status       = status;
        o_result.woken_valid  = woken;
        o_result.woken_thread = woken ? next_thread : '0;
        o_result.hold_count   = n_count;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.count = r_count;
    assign o_stat.fill  = r_fill;

endmodule
`default_nettype wire
